// ----- hdl/ebb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebb_pkg
// Shared sizes and types for the edge-normalized box blur.
// ----------------------------------------------------------------------------
package ebb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 31;
    localparam int STORE_ROWS  = MAX_KERNEL + 1;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = 16;
    localparam int SLOT_W  = $clog2(STORE_ROWS);
    localparam int KS_W    = 7;
    localparam int M_W     = $clog2(MAX_KERNEL / 2 + 1);
    localparam int SPAN_W  = $clog2(MAX_KERNEL + 1);
    localparam int CNT_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SUM_W   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
    localparam int IT_W    = $clog2(SUM_W + 1);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int DEPTH   = STORE_ROWS << COL_W;
    localparam int CFG_W   = 16;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    // per-lane control
    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
    } t_lane_ctl;

endpackage
`default_nettype wire

// ----- hdl/ebb_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ebb_lane
// One color lane: window accumulator and restoring divider for the mean.
// ----------------------------------------------------------------------------
module ebb_lane
    import ebb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_lane_ctl        i_ctl,
    input  wire logic [7:0]       i_sample,
    input  wire logic [CNT_W-1:0] i_count,
    output logic      [7:0]       o_mean,
    output logic                  o_done
);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_rem;
    logic [IT_W-1:0]  r_it;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_q[SUM_W-1]};
    assign ge    = trial >= {1'b0, i_count};

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SUM_W'(i_sample);
        end
        if (i_ctl.start) begin
            r_q   <= r_sum;
            r_rem <= '0;
            r_it  <= IT_W'(SUM_W);
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_rem <= ge ? CNT_W'(trial - {1'b0, i_count}) : trial[CNT_W-1:0];
            r_it  <= r_it - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_it == IT_W'(1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    assign o_mean = r_q[7:0];
    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- hdl/edge_normalized_box_blur.sv -----
`default_nettype none
// An item that releases no result goes from IDLE through CHECK and SETUP back to IDLE;
// one that releases a result goes on through SUM, DRAIN, START and DIV. SUM reads the
// R*C in-frame window cells, at most 961, one cell per cycle via the line store's single
// read port; the lanes divide the SUM_W (18) bit sum. The block takes one item at a time.
// Reset: synchronous, active low; state, counters and config registers go to their defaults,
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// edge_normalized_box_blur
// RGB box blur over a raster stream, with the mean taken over in-frame pixels.
// ----------------------------------------------------------------------------
module edge_normalized_box_blur
    import ebb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_mode,
    input  wire logic [7:0]       i_red_in,
    input  wire logic [7:0]       i_green_in,
    input  wire logic [7:0]       i_blue_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic      [7:0]       o_red_out,
    output logic      [7:0]       o_green_out,
    output logic      [7:0]       o_blue_out,
    output logic                  o_frame_last,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_START = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [WID_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    logic [KS_W-1:0]  r_ksize;

    // positions
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [SLOT_W-1:0] r_in_slot, r_out_slot;

    // window registers
    logic [ROW_W-1:0]  r_nr, r_r0, r_r;
    logic [COL_W-1:0]  r_nc, r_c0, r_c;
    logic [SLOT_W-1:0] r_slot0, r_slot;
    logic              r_last, r_ok;
    logic [CNT_W-1:0]  r_cnt;

    // line store
    logic [23:0]       mem [DEPTH];
    logic [23:0]       r_rd_data;
    logic              r_rd_vld;

    // output register
    logic              r_out_vld;
    logic [7:0]        r_red, r_green, r_blue;
    logic              r_flast;

    // effective settings
    logic [WID_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [KS_W-1:0]   k_odd, k_eff;
    logic [M_W-1:0]    m;
    logic [COL_W-1:0]  w_m1;
    logic [ROW_W-1:0]  h_m1;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? ROW_W'(1) : r_height;
        k_odd = r_ksize | KS_W'(1);
        if (k_odd < KS_W'(3)) begin
            k_eff = KS_W'(3);
        end else if (k_odd > KS_W'(MAX_KERNEL)) begin
            k_eff = KS_W'(MAX_KERNEL);
        end else begin
            k_eff = k_odd;
        end
        m    = M_W'((k_eff - 1'b1) >> 1);
        w_m1 = COL_W'(w_eff - 1'b1);
        h_m1 = h_eff - 1'b1;
    end

    // ---- handshake ----
    logic accept, store_px, in_col_end;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign store_px   = accept && !i_mode && (r_in_row < h_eff)
                        && ({1'b0, r_in_col} < w_eff);
    assign in_col_end = (r_in_col == w_m1);

    // ---- window bounds (CHECK) ----
    logic [ROW_W:0]    nr_raw;
    logic [COL_W:0]    nc_raw;
    logic [SLOT_W:0]   slot_sub;
    always_comb begin
        nr_raw   = {1'b0, r_out_row} + (ROW_W+1)'(m);
        nc_raw   = {1'b0, r_out_col} + (COL_W+1)'(m);
        slot_sub = (r_out_slot >= SLOT_W'(m))
                 ? (SLOT_W+1)'(r_out_slot - SLOT_W'(m))
                 : (SLOT_W+1)'(r_out_slot) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(m);
    end

    // ---- readiness and count (SETUP) ----
    logic ready_win;
    logic [SPAN_W-1:0] rows_n, cols_n;
    assign ready_win = (r_in_row > r_nr) || ((r_in_row == r_nr) && (r_in_col > r_nc));
    assign rows_n    = SPAN_W'(r_nr - r_r0) + 1'b1;
    assign cols_n    = SPAN_W'(r_nc - r_c0) + 1'b1;

    // ---- lanes ----
    t_lane_ctl lane_ctl;
    logic [2:0] lane_done;
    logic [7:0] mean_r, mean_g, mean_b;
    logic       load_out;

    assign lane_ctl.clear = (r_state == S_SETUP);
    assign lane_ctl.acc   = r_rd_vld;
    assign lane_ctl.start = (r_state == S_START);
    assign load_out = (r_state == S_DIV) && (&lane_done) && (!r_out_vld || i_out_ready);

    ebb_lane u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_sample(r_rd_data[23:16]), .i_count(r_cnt), .o_mean(mean_r), .o_done(lane_done[0])
    );
    ebb_lane u_lane_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_sample(r_rd_data[15:8]), .i_count(r_cnt), .o_mean(mean_g), .o_done(lane_done[1])
    );
    ebb_lane u_lane_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_sample(r_rd_data[7:0]), .i_count(r_cnt), .o_mean(mean_b), .o_done(lane_done[2])
    );

    // ---- sequencer ----
    logic sum_row_end, sum_last;
    assign sum_row_end = (r_c == r_nc);
    assign sum_last    = sum_row_end && (r_r == r_nr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_CHECK;
            S_CHECK: n_state = S_SETUP;
            S_SETUP: n_state = r_ok ? S_SUM : S_IDLE;
            S_SUM:   if (sum_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- memory ----
    always_ff @(posedge i_clk) begin
        if (store_px) begin
            mem[{r_in_slot, r_in_col}] <= {i_red_in, i_green_in, i_blue_in};
        end
        if (r_state == S_SUM) begin
            r_rd_data <= mem[{r_slot, r_c}];
        end
    end

    // ---- window payload ----
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_nr    <= (nr_raw > (ROW_W+1)'(h_m1)) ? h_m1 : nr_raw[ROW_W-1:0];
            r_nc    <= (nc_raw > (COL_W+1)'(w_m1)) ? w_m1 : nc_raw[COL_W-1:0];
            r_r0    <= (r_out_row > ROW_W'(m)) ? r_out_row - ROW_W'(m) : '0;
            r_c0    <= (r_out_col > COL_W'(m)) ? r_out_col - COL_W'(m) : '0;
            r_slot0 <= (r_out_row > ROW_W'(m)) ? slot_sub[SLOT_W-1:0] : '0;
            r_last  <= (r_out_row == h_m1) && (r_out_col == w_m1);
            r_ok    <= (r_out_row < h_eff) && ({1'b0, r_out_col} < w_eff);
        end
        if (r_state == S_SETUP) begin
            r_cnt  <= CNT_W'(rows_n * cols_n);
            r_r    <= r_r0;
            r_c    <= r_c0;
            r_slot <= r_slot0;
        end else if (r_state == S_SUM) begin
            if (sum_row_end) begin
                r_c    <= r_c0;
                r_r    <= r_r + 1'b1;
                r_slot <= (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
        if (load_out) begin
            r_red   <= mean_r;
            r_green <= mean_g;
            r_blue  <= mean_b;
            r_flast <= r_last;
        end
    end

    // ---- control registers ----
    logic commit;
    assign commit = (r_state == S_SETUP) && r_ok && ready_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_width    <= WID_W'(1024);
            r_height   <= ROW_W'(768);
            r_ksize    <= KS_W'(3);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= (r_state == S_SETUP && !ready_win) ? S_IDLE : n_state;
            r_rd_vld <= (r_state == S_SUM);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (store_px) begin
                if (in_col_end) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + 1'b1;
                    r_in_slot <= (r_in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                 : r_in_slot + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end

            // frame restart on the last pixel, else advance the output position
            if (commit) begin
                if (r_last) begin
                    r_in_row   <= '0;
                    r_in_col   <= '0;
                    r_in_slot  <= '0;
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_slot <= '0;
                end else if (r_out_col == w_m1) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + 1'b1;
                    r_out_slot <= (r_out_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                  : r_out_slot + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end

            // a write to the width, height or kernel register restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                    REG_KERNEL: r_ksize  <= i_cfg_data[KS_W-1:0];
                    default: ;
                endcase
                if (i_cfg_idx == REG_WIDTH || i_cfg_idx == REG_HEIGHT
                    || i_cfg_idx == REG_KERNEL) begin
                    r_in_row   <= '0;
                    r_in_col   <= '0;
                    r_in_slot  <= '0;
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_slot <= '0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_frame_last = r_flast;

`ifndef SYNTH
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
        else $error("lanes out of step");
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SUM |-> r_c <= r_nc && r_r <= r_nr)
        else $error("window walk out of bounds");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_CHECK)
        else $error("accepted beat not checked");
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |-> r_cnt != '0)
        else $error("zero divisor");
`endif

endmodule
`default_nettype wire

// ----- test/edge_normalized_box_blur_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_tb
// Drives small RGB frames through the blur with random idling on both
// channels and checks every output beat against a local mean-of-window model.
// ----------------------------------------------------------------------------
module edge_normalized_box_blur_tb;
    import ebb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_px;

    localparam int CYCLE_LIMIT = 10000000;

    // index past the register list
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_mode;
    logic [7:0]       i_red_in;
    logic [7:0]       i_green_in;
    logic [7:0]       i_blue_in;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [7:0]       o_red_out;
    logic [7:0]       o_green_out;
    logic [7:0]       o_blue_out;
    logic             o_frame_last;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    // model state: one frame store indexed by pixel position in the frame (frames kept small)
    logic [23:0] frame_px [0:65535];
    int unsigned cfg_width, cfg_height, cfg_kernel;
    int unsigned in_row, in_col, out_row, out_col;

    t_blur_px    blurred_q[$];
    int unsigned mismatch_cnt;
    int unsigned cycle_cnt;
    bit          stim_done;

    edge_normalized_box_blur u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic int unsigned half_window();
        int unsigned k;
        k = cfg_kernel;
        if (k[0] == 1'b0) k++;
        if (k < 3) k = 3;
        if (k > MAX_KERNEL) k = MAX_KERNEL;
        return (k - 1) / 2;
    endfunction

    // advances the model by one beat; pushes the result it releases, if any
    function automatic void predict_blur(logic mode, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
        int unsigned w, h, m, nr, nc, r0, c0, cnt, sr, sg, sb;
        t_blur_px    px;
        w = eff_width();
        h = eff_height();
        m = half_window();
        sr = 0; sg = 0; sb = 0;
        if (!mode && in_row < h && in_col < w) begin
            frame_px[(in_row * w + in_col) % 65536] = {r, g, b};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h || out_col >= w) return;
        nr = (out_row + m > h - 1) ? h - 1 : out_row + m;
        nc = (out_col + m > w - 1) ? w - 1 : out_col + m;
        if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
        r0 = (out_row > m) ? out_row - m : 0;
        c0 = (out_col > m) ? out_col - m : 0;
        cnt = (nr - r0 + 1) * (nc - c0 + 1);
        for (int unsigned y = r0; y <= nr; y++) begin
            for (int unsigned x = c0; x <= nc; x++) begin
                logic [23:0] v;
                v = frame_px[(y * w + x) % 65536];
                sr += v[23:16];
                sg += v[15:8];
                sb += v[7:0];
            end
        end
        px.red   = 8'(sr / cnt);
        px.green = 8'(sg / cnt);
        px.blue  = 8'(sb / cnt);
        px.last  = (out_row == h - 1) && (out_col == w - 1);
        blurred_q.push_back(px);
        if (px.last) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // one input beat, with a random gap first; valid stays up on back-to-back beats
    task automatic send_pixel(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_blur(mode, r, g, b);
    endtask

    // drops valid, waits for the queue to drain, then for the block to settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = value & 11'h7FF;
            REG_HEIGHT: cfg_height = value & 16'hFFFF;
            REG_KERNEL: cfg_kernel = value & 7'h7F;
            default: ;
        endcase
        if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_KERNEL) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned k);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_KERNEL, k);
    endtask

    // full frame of random pixels, then flush ticks until the last beat comes out
    task automatic run_frame(int unsigned extra);
        int unsigned n;
        n = eff_width() * eff_height();
        for (int unsigned i = 0; i < n; i++)
            send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        // extra pixels after the frame count as flush ticks
        for (int unsigned i = 0; i < extra; i++)
            send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        while (in_row != 0 || out_row != 0 || out_col != 0 || in_col != 0)
            send_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_extremes();
        set_frame(3, 3, 0);
        send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);     // early flush, no result
        for (int i = 0; i < 9; i++)
            send_pixel(1'b0, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF, 8'hAA);
        send_pixel(1'b0, 8'h55, 8'h55, 8'h55);     // extra pixel
        while (out_row != 0 || out_col != 0 || in_row != 0)
            send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
        set_frame(0, 0, 2);                         // single-pixel frame
        run_frame(1);
    endtask

    task automatic test_kernel_sizes();
        set_frame(5, 4, 127);
        run_frame(0);
        set_frame(20, 3, 31);
        run_frame(0);
        set_frame(2047, 1, 4);                      // width clamps to the maximum
        run_frame(0);
        set_frame(1, 40, 30);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        sent = 0;
        while (sent < 150) begin
            set_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 127));
            sent += eff_width() * eff_height();
            run_frame($urandom_range(0, 2));
        end
        write_reg(REG_UNUSED, 16'hFFFF);            // unused index, ignored
        set_frame(8, 65535, 9);                     // tall frame cut short by a write
        for (int i = 0; i < 60; i++)
            send_pixel(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        set_frame(6, 5, 5);
        run_frame(0);
    endtask

    // output stall and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (blurred_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    t_blur_px want;
                    want = blurred_q.pop_front();
                    if (o_red_out != want.red)
                        report_mismatch("red", o_red_out, want.red);
                    if (o_green_out != want.green)
                        report_mismatch("green", o_green_out, want.green);
                    if (o_blue_out != want.blue)
                        report_mismatch("blue", o_blue_out, want.blue);
                    if (o_frame_last != want.last)
                        report_mismatch("frame_last", o_frame_last, want.last);
                end
            end
            i_out_ready <= ($urandom_range(0, 15) < 10) || stim_done;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[edge_normalized_box_blur] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0; i_mode = 1'b0;
        i_red_in = '0; i_green_in = '0; i_blue_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cycle_cnt = 0; mismatch_cnt = 0; stim_done = 0;
        cfg_width = 1024; cfg_height = 768; cfg_kernel = 3;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_kernel_sizes();
        test_random_frames();
        stim_done = 1;
        wait_idle();
        if (mismatch_cnt == 0 && blurred_q.size() == 0) begin
            $display("[edge_normalized_box_blur] OK");
        end else begin
            $display("[edge_normalized_box_blur] ERROR");
        end
        $finish;
    end

endmodule
